// ----- src/stkt_pkg.sv -----
// stkt_pkg: types and constants shared by the sorted time-key table.
// No dependencies; used by stkt_cell, sorted_time_key_table and stkt_checker.
`timescale 1ns / 1ps
`default_nettype none

package stkt_pkg;

    localparam int CAPACITY = 8;
    localparam int IDX_W    = 3;   // slot_index / position field width
    localparam int CNT_W    = 4;   // entry_total field width
    localparam int KEY_W    = 11;  // {hour, minute}

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2
    } t_status;

    // What a cell loads at the next edge.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD_NEW,
        OP_FROM_LEFT,
        OP_FROM_RIGHT
    } t_cell_op;

    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] tag;
    } t_entry;

    // Compare results of a stored entry against the incoming key.
    typedef struct packed {
        logic lt;   // stored key < new key
        logic le;   // stored key <= new key
    } t_cell_flags;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [4:0]       event_hour;
        logic [5:0]       event_minute;
        logic [15:0]      event_tag;
        logic [IDX_W-1:0] slot_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] position;
        logic [4:0]       read_hour;
        logic [5:0]       read_minute;
        logic [15:0]      read_tag;
        logic [CNT_W-1:0] entry_total;
    } t_out_item;

endpackage

`default_nettype wire

// ----- src/stkt_cell.sv -----
// stkt_cell: one slot of the sorted chain; holds an entry, compares its key
// with the incoming key and shifts to/from its neighbors. Uses stkt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stkt_cell (
    input  wire logic                 i_clk,
    input  wire stkt_pkg::t_cell_op   i_op,
    input  wire stkt_pkg::t_entry     i_new,
    input  wire stkt_pkg::t_entry     i_left,
    input  wire stkt_pkg::t_entry     i_right,
    output stkt_pkg::t_entry          o_entry,
    output stkt_pkg::t_cell_flags     o_flags
);

    stkt_pkg::t_entry r_entry;
    stkt_pkg::t_entry n_entry;
    logic [stkt_pkg::KEY_W-1:0] w_key_own;
    logic [stkt_pkg::KEY_W-1:0] w_key_new;

    assign w_key_own = {r_entry.hour, r_entry.minute};
    assign w_key_new = {i_new.hour, i_new.minute};

    assign o_flags.lt = (w_key_own <  w_key_new);
    assign o_flags.le = (w_key_own <= w_key_new);
    assign o_entry    = r_entry;

    always_comb begin
        unique case (i_op)
            stkt_pkg::OP_HOLD:       n_entry = r_entry;
            stkt_pkg::OP_LOAD_NEW:   n_entry = i_new;
            stkt_pkg::OP_FROM_LEFT:  n_entry = i_left;
            stkt_pkg::OP_FROM_RIGHT: n_entry = i_right;
            default:                 n_entry = r_entry;
        endcase
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

// ----- src/sorted_time_key_table.sv -----
// sorted_time_key_table: bounded table kept sorted by (hour, minute), built as
// a chain of stkt_cell slots. Depends on stkt_pkg and stkt_cell.
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+-------------------------
//  in      | i_in_valid  | o_in_stall   | i_in_data  (t_in_item)
//  out     | o_out_valid | i_out_stall  | o_out_data (t_out_item)
//
// Every command is handled by the whole chain at once: all cells compare against
// the new key and shift in parallel, and the result lands in the output register at
// the same edge, so one command per cycle is sustained while the output is not stalled.
// Input stalls only while the output register holds a result that is stalled.
// Reset (i_rst_n low, synchronous) empties the table and the output register.
`timescale 1ns / 1ps
`default_nettype none

module sorted_time_key_table (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire stkt_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output stkt_pkg::t_out_item      o_out_data
);

    localparam int N = stkt_pkg::CAPACITY;

    logic [stkt_pkg::CNT_W-1:0] r_count;
    logic [stkt_pkg::CNT_W-1:0] n_count;
    logic                       r_out_valid;
    stkt_pkg::t_out_item        r_out;
    stkt_pkg::t_out_item        n_out;

    stkt_pkg::t_entry      w_entry [N];
    stkt_pkg::t_cell_flags w_flags [N];
    stkt_pkg::t_cell_op    w_op    [N];
    logic [N-1:0]          w_used;
    logic [N-1:0]          w_le;
    logic [N-1:0]          w_lt;
    stkt_pkg::t_entry      w_new;
    logic                  w_accept;
    logic                  w_full;
    logic                  w_idx_ok;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_new.hour   = i_in_data.event_hour;
    assign w_new.minute = i_in_data.event_minute;
    assign w_new.tag    = i_in_data.event_tag;

    assign w_full   = (r_count == stkt_pkg::CNT_W'(N));
    assign w_idx_ok = ({1'b0, i_in_data.slot_index} < r_count);

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            localparam int L = (g == 0) ? 0 : g - 1;
            localparam int R = (g == N - 1) ? g : g + 1;

            assign w_used[g] = (stkt_pkg::CNT_W'(g) < r_count);
            assign w_le[g]   = w_used[g] & w_flags[g].le;
            assign w_lt[g]   = w_used[g] & w_flags[g].lt;

            stkt_cell u_cell (
                .i_clk   (i_clk),
                .i_op    (w_op[g]),
                .i_new   (w_new),
                .i_left  (w_entry[L]),
                .i_right (w_entry[R]),
                .o_entry (w_entry[g]),
                .o_flags (w_flags[g])
            );
        end
    endgenerate

    // Per-cell shift control. Keys <= new stay put; the first slot past them
    // takes the new entry, the rest shift up. Delete shifts down from index.
    always_comb begin
        for (int i = 0; i < N; i++) begin
            w_op[i] = stkt_pkg::OP_HOLD;
            if (w_accept) begin
                if (i_in_data.cmd == stkt_pkg::CMD_INSERT && !w_full) begin
                    if (w_le[i]) begin
                        w_op[i] = stkt_pkg::OP_HOLD;
                    end else if (i == 0) begin
                        w_op[i] = stkt_pkg::OP_LOAD_NEW;
                    end else if (w_le[(i == 0) ? 0 : i - 1]) begin
                        w_op[i] = stkt_pkg::OP_LOAD_NEW;
                    end else begin
                        w_op[i] = stkt_pkg::OP_FROM_LEFT;
                    end
                end else if (i_in_data.cmd == stkt_pkg::CMD_DELETE && w_idx_ok) begin
                    if (stkt_pkg::IDX_W'(i) >= i_in_data.slot_index) begin
                        w_op[i] = stkt_pkg::OP_FROM_RIGHT;
                    end
                end
            end
        end
    end

    always_comb begin
        logic [stkt_pkg::CNT_W-1:0] v_less;
        stkt_pkg::t_entry           v_rd;
        v_less = '0;
        for (int i = 0; i < N; i++) begin
            v_less = v_less + stkt_pkg::CNT_W'(w_lt[i]);
        end
        v_rd    = w_entry[i_in_data.slot_index];
        n_count = r_count;
        n_out   = '0;
        unique case (i_in_data.cmd)
            stkt_pkg::CMD_INSERT: begin
                if (w_full) begin
                    n_out.status = stkt_pkg::ST_FULL;
                end else begin
                    // first equal key sits right after all smaller keys
                    n_out.position = v_less[stkt_pkg::IDX_W-1:0];
                    n_count        = r_count + 1'b1;
                end
            end
            stkt_pkg::CMD_DELETE: begin
                if (!w_idx_ok) begin
                    n_out.status = stkt_pkg::ST_BAD_INDEX;
                end else begin
                    n_out.position = i_in_data.slot_index;
                    n_count        = r_count - 1'b1;
                end
            end
            stkt_pkg::CMD_READ: begin
                if (!w_idx_ok) begin
                    n_out.status = stkt_pkg::ST_BAD_INDEX;
                end else begin
                    n_out.position    = i_in_data.slot_index;
                    n_out.read_hour   = v_rd.hour;
                    n_out.read_minute = v_rd.minute;
                    n_out.read_tag    = v_rd.tag;
                end
            end
            default: begin
                // unused command code: no change
            end
        endcase
        n_out.entry_total = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ----- src/stkt_checker.sv -----
// stkt_checker: port-level assertions for sorted_time_key_table, attached by
// the bind below. Depends on stkt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stkt_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire stkt_pkg::t_out_item o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // each input transfer gives a result at the next edge
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("missing result");

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.entry_total <= stkt_pkg::CAPACITY)
        else $error("entry total beyond capacity");

    a_full_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == stkt_pkg::ST_FULL
        |-> o_out_data.entry_total == stkt_pkg::CAPACITY && o_out_data.position == '0)
        else $error("full status with table not full");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != stkt_pkg::ST_OK
        |-> o_out_data.read_tag == '0 && o_out_data.read_hour == '0)
        else $error("error result carries read data");

endmodule

bind sorted_time_key_table stkt_checker u_stkt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// ----- test/tb_top.sv -----
// tb_top: self-checking bench for sorted_time_key_table (insert, delete, read).
// Depends on stkt_pkg and the RTL under src/. A directed table runs first, then
// random commands checked against a behavioral copy of the sorted table.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] CMD_UNUSED = 2'd3;   // undefined code, block ignores it
    localparam int RANDOM_ITEMS = 550;
    localparam int LONG_HOLD    = 60;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        stkt_pkg::t_in_item  item;
        bit                  fixed;
        stkt_pkg::t_out_item outcome;
    } t_stim_row;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    stkt_pkg::t_in_item  in_data;
    logic                out_valid;
    logic                out_stall;
    stkt_pkg::t_out_item out_data;

    sorted_time_key_table u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #10 clk = ~clk;

    // Shadow copy of the table
    stkt_pkg::t_entry    shadow_slots [stkt_pkg::CAPACITY];
    int unsigned         shadow_count;

    stkt_pkg::t_out_item outcome_queue [$];
    t_stim_row           stim_table [$];
    bit                  fixed_valid;
    stkt_pkg::t_out_item fixed_outcome;
    stkt_pkg::t_out_item predicted;

    bit          steady_flow;
    bit          hold_request;
    int unsigned stall_left;

    int unsigned cycle_count = 0;
    int unsigned mismatch_count;
    int unsigned accepted_count;
    int unsigned checked_count;
    int unsigned blocked_cycles;
    int unsigned full_count;
    int unsigned bad_index_count;

    function automatic stkt_pkg::t_out_item apply_table_command(stkt_pkg::t_in_item cmd_in);
        stkt_pkg::t_out_item        r;
        logic [stkt_pkg::KEY_W-1:0] key_new;
        logic [stkt_pkg::KEY_W-1:0] key_cur;
        int unsigned                first_eq;
        int unsigned                slot_at;
        bit                         found;
        int unsigned                i;
        r = '0;
        case (cmd_in.cmd)
            stkt_pkg::CMD_INSERT: begin
                if (shadow_count >= stkt_pkg::CAPACITY) begin
                    r.status = stkt_pkg::ST_FULL;
                end else begin
                    key_new  = {cmd_in.event_hour, cmd_in.event_minute};
                    first_eq = shadow_count;
                    slot_at  = shadow_count;
                    found    = 1'b0;
                    for (i = 0; i < shadow_count; i++) begin
                        key_cur = {shadow_slots[i].hour, shadow_slots[i].minute};
                        if (!found && key_cur == key_new && first_eq == shadow_count)
                            first_eq = i;
                        if (!found && key_cur > key_new) begin
                            slot_at = i;
                            found   = 1'b1;
                        end
                    end
                    if (first_eq > slot_at)
                        first_eq = slot_at;
                    for (i = shadow_count; i > slot_at; i--)
                        shadow_slots[i] = shadow_slots[i-1];
                    shadow_slots[slot_at] = '{cmd_in.event_hour, cmd_in.event_minute,
                                              cmd_in.event_tag};
                    shadow_count++;
                    r.position = first_eq[stkt_pkg::IDX_W-1:0];
                end
            end
            stkt_pkg::CMD_DELETE: begin
                if (cmd_in.slot_index >= shadow_count) begin
                    r.status = stkt_pkg::ST_BAD_INDEX;
                end else begin
                    for (i = cmd_in.slot_index; i + 1 < shadow_count; i++)
                        shadow_slots[i] = shadow_slots[i+1];
                    shadow_count--;
                    r.position = cmd_in.slot_index;
                end
            end
            stkt_pkg::CMD_READ: begin
                if (cmd_in.slot_index >= shadow_count) begin
                    r.status = stkt_pkg::ST_BAD_INDEX;
                end else begin
                    r.position    = cmd_in.slot_index;
                    r.read_hour   = shadow_slots[cmd_in.slot_index].hour;
                    r.read_minute = shadow_slots[cmd_in.slot_index].minute;
                    r.read_tag    = shadow_slots[cmd_in.slot_index].tag;
                end
            end
            default: ;
        endcase
        r.entry_total = shadow_count[stkt_pkg::CNT_W-1:0];
        return r;
    endfunction

    function automatic string show_outcome(stkt_pkg::t_out_item o);
        return $sformatf("st=%0d pos=%0d hr=%0d min=%0d tag=%h total=%0d",
                         o.status, o.position, o.read_hour, o.read_minute,
                         o.read_tag, o.entry_total);
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("mismatch @%0t: %s", $time, msg);
    endtask

    task automatic check_outcome(input stkt_pkg::t_out_item exp,
                                 input stkt_pkg::t_out_item got);
        string diff;
        diff = "";
        if (got.status      !== exp.status)      diff = {diff, " status"};
        if (got.position    !== exp.position)    diff = {diff, " position"};
        if (got.read_hour   !== exp.read_hour)   diff = {diff, " read_hour"};
        if (got.read_minute !== exp.read_minute) diff = {diff, " read_minute"};
        if (got.read_tag    !== exp.read_tag)    diff = {diff, " read_tag"};
        if (got.entry_total !== exp.entry_total) diff = {diff, " entry_total"};
        if (diff != "")
            note_mismatch($sformatf("result %0d field(s)%s: expected %s, got %s",
                                    checked_count, diff, show_outcome(exp),
                                    show_outcome(got)));
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int unsigned idle_length(bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic stkt_pkg::t_in_item cmd_item(logic [1:0] c, logic [4:0] h,
                                                    logic [5:0] m, logic [15:0] t,
                                                    logic [stkt_pkg::IDX_W-1:0] x);
        stkt_pkg::t_in_item it;
        it.cmd          = c;
        it.event_hour   = h;
        it.event_minute = m;
        it.event_tag    = t;
        it.slot_index   = x;
        return it;
    endfunction

    function automatic stkt_pkg::t_out_item status_item(logic [1:0] s,
                                                        logic [stkt_pkg::IDX_W-1:0] p,
                                                        logic [stkt_pkg::CNT_W-1:0] n);
        stkt_pkg::t_out_item o;
        o             = '0;
        o.status      = s;
        o.position    = p;
        o.entry_total = n;
        return o;
    endfunction

    // Fill and drain phases alternate so the count sweeps empty to full
    function automatic stkt_pkg::t_in_item random_command(int unsigned n);
        stkt_pkg::t_in_item it;
        int unsigned        r;
        int unsigned        insert_pct;
        insert_pct = ((n / 40) % 2 == 0) ? 70 : 32;
        r = $urandom_range(0, 99);
        if (r < 4)
            it.cmd = CMD_UNUSED;
        else if (r < insert_pct)
            it.cmd = stkt_pkg::CMD_INSERT;
        else if ($urandom_range(0, 1) == 0)
            it.cmd = stkt_pkg::CMD_DELETE;
        else
            it.cmd = stkt_pkg::CMD_READ;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            it.event_hour   = 5'($urandom_range(0, 23));
            it.event_minute = 6'($urandom_range(0, 59));
        end else if (r < 85) begin
            // narrow key space so equal times pile up
            it.event_hour   = 5'($urandom_range(0, 1));
            it.event_minute = 6'($urandom_range(0, 2));
        end else begin
            it.event_hour   = 5'($urandom_range(0, 31));
            it.event_minute = 6'($urandom_range(0, 63));
        end
        it.event_tag = 16'($urandom_range(0, 65535));
        if (shadow_count != 0 && $urandom_range(0, 4) != 0)
            it.slot_index = stkt_pkg::IDX_W'($urandom_range(0, shadow_count - 1));
        else
            it.slot_index = stkt_pkg::IDX_W'($urandom_range(0, stkt_pkg::CAPACITY - 1));
        return it;
    endfunction

    // Sender: starts and ends at a falling edge
    task automatic offer_command(input stkt_pkg::t_in_item cmd_in, input bit has_fixed,
                                 input stkt_pkg::t_out_item fixed_out);
        int unsigned gap;
        gap = idle_length(steady_flow);
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data       = cmd_in;
        fixed_valid   = has_fixed;
        fixed_outcome = fixed_out;
        in_valid      = 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Transfer monitor for both channels
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                predicted = apply_table_command(in_data);
                if (predicted.status == stkt_pkg::ST_FULL)      full_count++;
                if (predicted.status == stkt_pkg::ST_BAD_INDEX) bad_index_count++;
                outcome_queue.push_back(fixed_valid ? fixed_outcome : predicted);
                accepted_count++;
            end
            if (in_valid && in_stall)
                blocked_cycles++;
            if (out_valid && !out_stall) begin
                if (outcome_queue.size() == 0)
                    note_mismatch($sformatf("result with nothing pending: %s",
                                            show_outcome(out_data)));
                else
                    check_outcome(outcome_queue.pop_front(), out_data);
                checked_count++;
            end
        end
    end

    // Receiver stall pattern, with one long hold on request
    initial begin
        out_stall  = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end else if (stall_left == 0 && !steady_flow && $urandom_range(0, 2) == 0) begin
                stall_left = idle_length(1'b0);
            end
            out_stall = (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        fixed_valid  = 1'b0;
        fixed_outcome = '0;
        steady_flow  = 1'b0;
        hold_request = 1'b0;
        mismatch_count = 0;
        accepted_count = 0;
        checked_count  = 0;
        blocked_cycles = 0;
        full_count     = 0;
        bad_index_count = 0;
        shadow_count = 0;
        foreach (shadow_slots[i])
            shadow_slots[i] = '0;

        // empty table, fill to capacity with duplicates and odd keys, then unwind
        stim_table.push_back('{cmd_item(stkt_pkg::CMD_READ, 0, 0, 0, 0), 1'b1,
                               status_item(stkt_pkg::ST_BAD_INDEX, 0, 0)});
        stim_table.push_back('{cmd_item(stkt_pkg::CMD_DELETE, 0, 0, 0, 7), 1'b1,
                               status_item(stkt_pkg::ST_BAD_INDEX, 0, 0)});
        stim_table.push_back('{cmd_item(CMD_UNUSED, 31, 63, 16'hFFFF, 7), 1'b1,
                               status_item(stkt_pkg::ST_OK, 0, 0)});
        stim_table.push_back('{cmd_item(stkt_pkg::CMD_INSERT, 23, 59, 16'hFFFF, 0), 1'b1,
                               status_item(stkt_pkg::ST_OK, 0, 1)});
        stim_table.push_back('{cmd_item(stkt_pkg::CMD_INSERT, 0, 0, 16'h0000, 7), 1'b1,
                               status_item(stkt_pkg::ST_OK, 0, 2)});
        stim_table.push_back('{cmd_item(stkt_pkg::CMD_INSERT, 12, 30, 16'h1234, 0),
                               1'b0, '0});
        stim_table.push_back('{cmd_item(stkt_pkg::CMD_INSERT, 12, 30, 16'h5678, 0),
                               1'b0, '0});
        stim_table.push_back('{cmd_item(stkt_pkg::CMD_INSERT, 31, 63, 16'hAAAA, 0),
                               1'b0, '0});
        stim_table.push_back('{cmd_item(stkt_pkg::CMD_INSERT, 12, 30, 16'h5555, 0),
                               1'b0, '0});
        stim_table.push_back('{cmd_item(stkt_pkg::CMD_INSERT, 0, 0, 16'h0001, 0),
                               1'b0, '0});
        stim_table.push_back('{cmd_item(stkt_pkg::CMD_INSERT, 23, 59, 16'h0002, 0),
                               1'b0, '0});
        stim_table.push_back('{cmd_item(stkt_pkg::CMD_INSERT, 5, 5, 16'h7777, 0), 1'b1,
                               status_item(stkt_pkg::ST_FULL, 0, 8)});
        stim_table.push_back('{cmd_item(stkt_pkg::CMD_READ, 0, 0, 0, 7), 1'b0, '0});
        stim_table.push_back('{cmd_item(stkt_pkg::CMD_READ, 31, 63, 16'hFFFF, 0),
                               1'b0, '0});
        stim_table.push_back('{cmd_item(stkt_pkg::CMD_READ, 0, 0, 0, 3), 1'b0, '0});
        stim_table.push_back('{cmd_item(stkt_pkg::CMD_DELETE, 0, 0, 0, 7), 1'b0, '0});
        stim_table.push_back('{cmd_item(stkt_pkg::CMD_READ, 0, 0, 0, 7), 1'b1,
                               status_item(stkt_pkg::ST_BAD_INDEX, 0, 7)});
        stim_table.push_back('{cmd_item(stkt_pkg::CMD_DELETE, 0, 0, 0, 0), 1'b0, '0});
        stim_table.push_back('{cmd_item(CMD_UNUSED, 0, 0, 0, 5), 1'b0, '0});
        stim_table.push_back('{cmd_item(stkt_pkg::CMD_DELETE, 0, 0, 0, 3), 1'b0, '0});
        stim_table.push_back('{cmd_item(stkt_pkg::CMD_READ, 0, 0, 0, 3), 1'b0, '0});
        stim_table.push_back('{cmd_item(stkt_pkg::CMD_INSERT, 12, 30, 16'h9999, 0),
                               1'b0, '0});

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (stim_table[i])
            offer_command(stim_table[i].item, stim_table[i].fixed, stim_table[i].outcome);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady_flow = (n >= 100 && n < 150) || (n >= 200 && n < 230) ||
                          (n >= 420 && n < 460);
            if (n == 200)
                hold_request = 1'b1;    // receiver sits still, sender keeps pushing
            if (n == 350) begin
                in_valid = 1'b0;
                while (outcome_queue.size() != 0) @(negedge clk);
            end
            offer_command(random_command(n), 1'b0, '0);
        end
        in_valid    = 1'b0;
        steady_flow = 1'b0;

        while (outcome_queue.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (outcome_queue.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", outcome_queue.size()));

        $display("run covered %0d commands, %0d results checked, %0d mismatches",
                 accepted_count, checked_count, mismatch_count);
        $display("  %0d full inserts, %0d bad indexes, input held off %0d cycles",
                 full_count, bad_index_count, blocked_cycles);
        if (mismatch_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
